// ===== hdl/wli_pkg.sv =====
package wli_pkg;

  localparam int CH_W      = 32;
  localparam int NCHAN     = 4;
  localparam int CH_IDX_W  = 2;
  localparam int ROW_W     = CH_W * NCHAN;
  localparam int PTS_W     = 11;
  localparam int IDX_W     = 10;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

  typedef logic [NCHAN-1:0][CH_W-1:0] row_t;
  typedef logic [CH_IDX_W-1:0] ch_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTS = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RDA,
    S_RDB,
    S_CAPB,
    S_MUL,
    S_ADD,
    S_FIN
  } state_t;

endpackage

// ===== hdl/wli_ram.sv =====
module wli_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/wli_div.sv =====
module wli_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? VW'(rem_sh - {1'b0, dvs_r}) : VW'(rem_sh);
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/wli_blend.sv =====
module wli_blend
  import wli_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   mul_en,
  input  logic signed [CH_W-1:0] a,
  input  logic signed [CH_W-1:0] b,
  input  logic [FRAC_BITS-1:0]   frac,
  output logic signed [CH_W-1:0] res
);

  localparam int PW = CH_W + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF =
    {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  logic signed [CH_W:0]      diff;
  logic signed [FRAC_BITS:0] fs;
  logic signed [PW-1:0]      prod_r, prod_nxt;
  logic signed [PW-1:0]      rnd;
  logic signed [PW-1:0]      shifted;

  assign diff     = {b[CH_W-1], b} - {a[CH_W-1], a};
  assign fs       = {1'b0, frac};
  assign prod_nxt = diff * fs;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign rnd     = prod_r + HALF;
  assign shifted = rnd >>> FRAC_BITS;
  assign res     = a + signed'(shifted[CH_W-1:0]);

endmodule

// ===== hdl/waypoint_linear_interpolator.sv =====
// load request: written to the table in the accept cycle, no result
// query request: result set by the bit-per-cycle divider (32 + FRAC_BITS quotient bits),
// two table reads and a multiply and an add step for each of the 4 channels
// past the end: divide and one table read; zero period: one table read; empty table: no read
// one request in flight; the next is taken once the result sits in the output register
// reset: count 0, period 1000, control idle; table contents undefined until loaded
module waypoint_linear_interpolator
  import wli_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [IDX_W-1:0]       in_waypoint_index,
  input  logic signed [CH_W-1:0] in_way_x,
  input  logic signed [CH_W-1:0] in_way_y,
  input  logic signed [CH_W-1:0] in_way_z,
  input  logic signed [CH_W-1:0] in_way_yaw,
  input  logic [TIME_W-1:0]      in_time_us,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CH_W-1:0] out_x,
  output logic signed [CH_W-1:0] out_y,
  output logic signed [CH_W-1:0] out_z,
  output logic signed [CH_W-1:0] out_yaw,
  output logic                   out_table_empty,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = TIME_W + FRAC_BITS;

  state_t                 state_r, state_nxt;
  logic [PTS_W-1:0]       points_r;
  logic [PERIOD_W-1:0]    period_r;

  logic                   in_acc;
  logic [CNT_W-1:0]       n_w;
  logic [AW-1:0]          last_idx;

  logic                   div_start, div_done;
  logic [DW-1:0]          quot;
  logic [TIME_W-1:0]      q_seg;
  logic                   q_hold;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_raddr;
  row_t                   ram_wdata, ram_rdata;

  logic [AW-1:0]          seg_r;
  logic                   hold_r;
  logic [FRAC_BITS-1:0]   frac_r;
  row_t                   a_r, b_r, res_r;
  logic                   empty_r;
  ch_t                    ch_r;
  logic                   mul_en;
  logic signed [CH_W-1:0] blend_res;

  logic                   out_load;
  logic                   out_valid_r;
  row_t                   out_row_r;
  logic                   out_empty_r;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign n_w      = ({{(32 - PTS_W){1'b0}}, points_r} > 32'(MAX_POINTS)) ?
                    CNT_W'(MAX_POINTS) : CNT_W'(points_r);
  assign last_idx = AW'(n_w - CNT_W'(1));

  assign q_seg  = quot[DW-1:FRAC_BITS];
  assign q_hold = q_seg >= TIME_W'(last_idx);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINTS: points_r <= cfg_data[PTS_W-1:0];
        CFG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  assign ram_we    = in_acc && (in_cmd == CMD_LOAD) &&
                     (32'(in_waypoint_index) < 32'(MAX_POINTS));
  assign ram_wdata = {in_way_yaw, in_way_z, in_way_y, in_way_x};

  wli_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_waypoint_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wli_div #(
    .DW (DW),
    .VW (PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({in_time_us, {FRAC_BITS{1'b0}}}),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (quot)
  );

  wli_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (signed'(a_r[ch_r])),
    .b      (signed'(b_r[ch_r])),
    .frac   (frac_r),
    .res    (blend_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = seg_r;
    mul_en    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_QUERY)) begin
          if (n_w == '0) begin
            state_nxt = S_FIN;
          end else if (period_r == '0) begin
            state_nxt = S_RDA;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        ram_re    = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        if (hold_r) begin
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = seg_r + AW'(1);
          state_nxt = S_CAPB;
        end
      end
      S_CAPB: state_nxt = S_MUL;
      S_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = (ch_r == ch_t'(NCHAN - 1)) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_QUERY)) begin
          seg_r   <= last_idx;
          hold_r  <= 1'b1;
          frac_r  <= '0;
          empty_r <= (n_w == '0);
          res_r   <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          seg_r  <= q_hold ? last_idx : AW'(q_seg);
          hold_r <= q_hold;
          frac_r <= quot[FRAC_BITS-1:0];
        end
      end
      S_RDB: begin
        a_r <= ram_rdata;
        if (hold_r) begin
          res_r <= ram_rdata;
        end
      end
      S_CAPB: begin
        b_r  <= ram_rdata;
        ch_r <= '0;
      end
      S_ADD: begin
        res_r[ch_r] <= blend_res;
        ch_r        <= ch_r + ch_t'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_row_r   <= res_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = signed'(out_row_r[0]);
  assign out_y           = signed'(out_row_r[1]);
  assign out_z           = signed'(out_row_r[2]);
  assign out_yaw         = signed'(out_row_r[3]);
  assign out_table_empty = out_empty_r;

  a_second_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDB && !hold_r) |-> (32'(seg_r) < 32'(last_idx)))
    else $error("second table read past last point");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && empty_r) |-> (res_r == '0))
    else $error("empty table result not zero");

  a_load_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import wli_pkg::*;

  localparam int MAX_POINTS = 1024;
  localparam int FRAC_BITS = 16;
  localparam int FILL_POINTS = 256;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    row_t             way;
    logic [TIME_W-1:0] t;
  } request_t;

  typedef struct {
    row_t pos;
    logic empty;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = 1'b0;
  logic [IDX_W-1:0]       in_waypoint_index = '0;
  logic signed [CH_W-1:0] in_way_x = '0;
  logic signed [CH_W-1:0] in_way_y = '0;
  logic signed [CH_W-1:0] in_way_z = '0;
  logic signed [CH_W-1:0] in_way_yaw = '0;
  logic [TIME_W-1:0]      in_time_us = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CH_W-1:0] out_x;
  logic signed [CH_W-1:0] out_y;
  logic signed [CH_W-1:0] out_z;
  logic signed [CH_W-1:0] out_yaw;
  logic                   out_table_empty;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  request_t request_queue[$];
  point_t   due_points[$];
  request_t held;
  row_t     waypoint_rows [MAX_POINTS];
  logic [PTS_W-1:0]    pts_setting = '0;
  logic [PERIOD_W-1:0] period_setting = PERIOD_RESET;
  bit       calm = 1'b0;
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  row_t     got;
  point_t   want;
  string    chan_name [NCHAN] = '{"x", "y", "z", "yaw"};

  waypoint_linear_interpolator #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_waypoint_index(in_waypoint_index),
    .in_way_x         (in_way_x),
    .in_way_y         (in_way_y),
    .in_way_z         (in_way_z),
    .in_way_yaw       (in_way_yaw),
    .in_time_us       (in_time_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_yaw          (out_yaw),
    .out_table_empty  (out_table_empty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                  longint f);
    longint sa;
    longint sb;
    longint s;
    sa = $signed(a);
    sb = $signed(b);
    s = sa * ((longint'(1) << FRAC_BITS) - f) + sb * f;
    s = (s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return s[CH_W-1:0];
  endfunction

  function automatic longint unsigned points_used();
    return (pts_setting > MAX_POINTS) ? MAX_POINTS : pts_setting;
  endfunction

  function automatic void apply_request(request_t r);
    point_t e;
    longint unsigned n;
    longint unsigned last;
    longint unsigned seg;
    longint unsigned frac;
    longint unsigned q;
    longint unsigned tt;
    longint unsigned pp;
    int c;
    if (r.cmd == CMD_LOAD) begin
      waypoint_rows[r.idx] = r.way;
      return;
    end
    n = points_used();
    e.pos = '0;
    e.empty = (n == 0);
    if (n != 0) begin
      last = n - 1;
      seg = last;
      frac = 0;
      if (period_setting != 0) begin
        tt = r.t;
        pp = period_setting;
        q = (tt << FRAC_BITS) / pp;
        seg = q >> FRAC_BITS;
        frac = q & ((64'd1 << FRAC_BITS) - 1);
      end
      for (c = 0; c < NCHAN; c++) begin
        if (seg >= last) begin
          e.pos[c] = waypoint_rows[last][c];
        end else begin
          e.pos[c] = mix_channel(waypoint_rows[seg][c], waypoint_rows[seg + 1][c], frac);
        end
      end
    end
    due_points.push_back(e);
  endfunction

  function automatic row_t random_row();
    row_t w;
    int c;
    for (c = 0; c < NCHAN; c++) begin
      case ($urandom_range(0, 7))
        0: w[c] = 32'h7FFF_FFFF;
        1: w[c] = 32'h8000_0000;
        2: w[c] = '0;
        3: w[c] = '1;
        4: w[c] = $urandom_range(0, 2000) - 1000;
        default: w[c] = $urandom;
      endcase
    end
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    longint unsigned n;
    longint unsigned span;
    n = points_used();
    span = period_setting * (n + 1);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? '1 : '0;
      2: return TIME_W'(period_setting * $urandom_range(0, 32'(n)));
      3: return TIME_W'(period_setting * $urandom_range(0, 32'(n)) + period_setting / 2);
      default: return TIME_W'($urandom_range(0, 32'(span)));
    endcase
  endfunction

  function automatic void push_load(logic [IDX_W-1:0] idx, row_t w);
    request_t r;
    r.cmd = CMD_LOAD;
    r.idx = idx;
    r.way = w;
    r.t = $urandom;
    request_queue.push_back(r);
  endfunction

  function automatic void push_query(logic [TIME_W-1:0] t);
    request_t r;
    r.cmd = CMD_QUERY;
    r.idx = IDX_W'($urandom);
    r.way = random_row();
    r.t = t;
    request_queue.push_back(r);
  endfunction

  task automatic write_reg(cfg_idx_t r, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (r == CFG_POINTS) begin
      pts_setting = v[PTS_W-1:0];
    end else begin
      period_setting = v;
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || due_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [PTS_W-1:0] pts, logic [PERIOD_W-1:0] per, int count,
                           bit steady);
    write_reg(CFG_POINTS, CFG_W'(pts));
    write_reg(CFG_PERIOD, per);
    calm = steady;
    repeat (count) begin
      if ($urandom_range(0, 99) < 20) begin
        push_load(IDX_W'($urandom_range(0, MAX_POINTS - 1)), random_row());
      end else begin
        push_query(pick_time());
      end
    end
    settle();
    calm = 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(held);
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          held = request_queue.pop_front();
          in_valid <= 1'b1;
          in_cmd <= held.cmd;
          in_waypoint_index <= held.idx;
          in_way_x <= held.way[0];
          in_way_y <= held.way[1];
          in_way_z <= held.way[2];
          in_way_yaw <= held.way[3];
          in_time_us <= held.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_yaw, out_z, out_y, out_x};
        if (due_points.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x=%h y=%h z=%h yaw=%h",
                   $time, out_x, out_y, out_z, out_yaw);
          mismatch_count++;
        end else begin
          want = due_points.pop_front();
          for (int c = 0; c < NCHAN; c++) begin
            if (got[c] !== want.pos[c]) begin
              $display("%0t: %s expected %h actual %h", $time, chan_name[c], want.pos[c],
                       got[c]);
              mismatch_count++;
            end
          end
          if (out_table_empty !== want.empty) begin
            $display("%0t: table_empty expected %b actual %b", $time, want.empty,
                     out_table_empty);
            mismatch_count++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 16);
    end
  end

  // watchdog on handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table right after reset
    push_query('0);
    push_query('1);
    push_load(10'd0, {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    push_load(10'd1, {32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    push_load(10'd1023, random_row());
    settle();

    // single point held for every time
    write_reg(CFG_POINTS, CFG_W'(1));
    push_query('0);
    push_query('1);
    settle();

    // two points at the reset period, including the exact half blend
    write_reg(CFG_POINTS, CFG_W'(2));
    push_query(32'd0);
    push_query(32'd1);
    push_query(32'd500);
    push_query(32'd999);
    push_query(32'd1000);
    push_query(32'd1500);
    push_query(32'd2000);
    push_query('1);
    settle();

    // fill the low part of the table, queries mixed in
    write_reg(CFG_PERIOD, CFG_W'(3));
    calm = 1'b1;
    for (int i = 0; i < FILL_POINTS; i++) begin
      push_load(IDX_W'(i), random_row());
      if ($urandom_range(0, 99) < 15) push_query(pick_time());
    end
    settle();
    calm = 1'b0;

    run_phase(PTS_W'(1), PERIOD_W'(1), 50, 1'b0);
    run_phase(PTS_W'(3), PERIOD_W'(7), 60, 1'b0);
    run_phase(PTS_W'($urandom_range(4, 40)), PERIOD_W'($urandom_range(1, 5000)), 70, 1'b0);
    run_phase(PTS_W'(FILL_POINTS), PERIOD_W'($urandom_range(1, 300)), 70, 1'b1);
    // count above the table depth, only the last entry is read
    run_phase(PTS_W'(2047), '0, 50, 1'b0);
    run_phase(PTS_W'($urandom_range(2, FILL_POINTS)), PERIOD_W'(1), 40, 1'b0);
    run_phase(PTS_W'($urandom_range(2, 200)), '1, 50, 1'b0);
    run_phase(PTS_W'($urandom_range(2, FILL_POINTS)), $urandom, 60, 1'b0);
    run_phase(PTS_W'(2), PERIOD_W'(1000), 60, 1'b0);
    run_phase('0, $urandom, 30, 1'b0);

    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
